// ===== rtl/emd_pkg.sv =====
// Package: shared constants and types for the energy meter packet deframer.
package emd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RAW_W   = 24;
  localparam int unsigned SCALE_W = 24;
  localparam int unsigned PROD_W  = RAW_W + SCALE_W;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [IDX_W-1:0] PKT_LAST = IDX_W'(23);
  localparam logic [IDX_W-1:0] V_POS    = IDX_W'(6);
  localparam logic [IDX_W-1:0] I_POS    = IDX_W'(15);
  localparam logic [IDX_W-1:0] P_POS    = IDX_W'(18);

  localparam logic [SCALE_W-1:0] VOLTAGE_SCALE_RST = SCALE_W'(167772);
  localparam logic [SCALE_W-1:0] CURRENT_SCALE_RST = SCALE_W'(16777);
  localparam logic [SCALE_W-1:0] POWER_SCALE_RST   = SCALE_W'(167772);

  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_SCALE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SCALE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_POWER_SCALE   = CFG_IDX_W'(2);

  typedef struct packed {
    logic               ok;
    logic [RAW_W-1:0]   voltage_raw;
    logic [RAW_W-1:0]   current_raw;
    logic [RAW_W-1:0]   power_raw;
    logic [BYTE_W-1:0]  received_sum;
    logic [BYTE_W-1:0]  computed_sum;
  } pkt_t;

  typedef struct packed {
    logic [SCALE_W-1:0] voltage_scale;
    logic [SCALE_W-1:0] current_scale;
    logic [SCALE_W-1:0] power_scale;
  } scales_t;

endpackage

// ===== rtl/emd_byte_if.sv =====
// Interface: received byte channel.
interface emd_byte_if;
  logic                       valid;
  logic                       ready;
  logic [emd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/emd_result_if.sv =====
// Interface: packet result channel.
interface emd_result_if;
  logic                        valid;
  logic                        ready;
  logic                        checksum_ok;
  logic [emd_pkg::RAW_W-1:0]   voltage_raw;
  logic [emd_pkg::RAW_W-1:0]   current_raw;
  logic [emd_pkg::RAW_W-1:0]   power_raw;
  logic [emd_pkg::PROD_W-1:0]  voltage_scaled;
  logic [emd_pkg::PROD_W-1:0]  current_scaled;
  logic [emd_pkg::PROD_W-1:0]  power_scaled;
  logic [emd_pkg::BYTE_W-1:0]  received_sum;
  logic [emd_pkg::BYTE_W-1:0]  computed_sum;

  modport source (output valid, output checksum_ok, output voltage_raw, output current_raw,
                  output power_raw, output voltage_scaled, output current_scaled,
                  output power_scaled, output received_sum, output computed_sum,
                  input ready);
  modport sink   (input valid, input checksum_ok, input voltage_raw, input current_raw,
                  input power_raw, input voltage_scaled, input current_scaled,
                  input power_scaled, input received_sum, input computed_sum,
                  output ready);
endinterface

// ===== rtl/emd_framer.sv =====
// Framer: byte counter, running checksum, field capture and packet register.
module emd_framer (
  input  logic              clk,
  input  logic              rst,
  emd_byte_if.sink          rx,
  output logic              pkt_valid,
  input  logic              pkt_ready,
  output emd_pkg::pkt_t     pkt
);

  logic [emd_pkg::IDX_W-1:0]  byte_index;
  logic [emd_pkg::BYTE_W-1:0] running_sum;
  logic [emd_pkg::RAW_W-1:0]  voltage_capture;
  logic [emd_pkg::RAW_W-1:0]  current_capture;
  logic [emd_pkg::RAW_W-1:0]  power_capture;
  logic                       accept;
  logic [emd_pkg::BYTE_W-1:0] b;
  logic                       pkt_valid_next;

  assign rx.ready = !pkt_valid || pkt_ready;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  assign pkt_valid_next = (accept && byte_index == emd_pkg::PKT_LAST) ||
                          (pkt_valid && !pkt_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= '0;
      running_sum     <= '0;
      voltage_capture <= '0;
      current_capture <= '0;
      power_capture   <= '0;
      pkt_valid       <= 1'b0;
    end else begin
      pkt_valid <= pkt_valid_next;
      if (accept) begin
        if (byte_index < emd_pkg::PKT_LAST) begin
          running_sum <= running_sum + b;
          byte_index  <= byte_index + emd_pkg::IDX_W'(1);
          if (byte_index >= emd_pkg::V_POS && byte_index < emd_pkg::V_POS + emd_pkg::IDX_W'(3))
          begin
            voltage_capture <= {voltage_capture[emd_pkg::RAW_W-emd_pkg::BYTE_W-1:0], b};
          end
          if (byte_index >= emd_pkg::I_POS && byte_index < emd_pkg::I_POS + emd_pkg::IDX_W'(3))
          begin
            current_capture <= {current_capture[emd_pkg::RAW_W-emd_pkg::BYTE_W-1:0], b};
          end
          if (byte_index >= emd_pkg::P_POS && byte_index < emd_pkg::P_POS + emd_pkg::IDX_W'(3))
          begin
            power_capture <= {power_capture[emd_pkg::RAW_W-emd_pkg::BYTE_W-1:0], b};
          end
        end else begin
          // last byte emits a packet; an index past the end just restarts
          byte_index  <= '0;
          running_sum <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_index == emd_pkg::PKT_LAST) begin
      pkt.ok           <= (b == running_sum);
      pkt.voltage_raw  <= voltage_capture;
      pkt.current_raw  <= current_capture;
      pkt.power_raw    <= power_capture;
      pkt.received_sum <= b;
      pkt.computed_sum <= running_sum;
    end
  end

endmodule

// ===== rtl/emd_scaler.sv =====
// Scaler: product stage, held values and result output register.
module emd_scaler (
  input  logic              clk,
  input  logic              rst,
  input  logic              pkt_valid,
  output logic              pkt_ready,
  input  emd_pkg::pkt_t     pkt,
  input  emd_pkg::scales_t  scales,
  emd_result_if.source      result
);

  logic                        prod_valid;
  emd_pkg::pkt_t               prod_pkt;
  logic [emd_pkg::PROD_W-1:0]  voltage_prod;
  logic [emd_pkg::PROD_W-1:0]  current_prod;
  logic [emd_pkg::PROD_W-1:0]  power_prod;
  logic                        prod_go;
  logic [emd_pkg::PROD_W-1:0]  voltage_held;
  logic [emd_pkg::PROD_W-1:0]  current_held;
  logic [emd_pkg::PROD_W-1:0]  power_held;
  logic [emd_pkg::PROD_W-1:0]  voltage_held_next;
  logic [emd_pkg::PROD_W-1:0]  current_held_next;
  logic [emd_pkg::PROD_W-1:0]  power_held_next;
  logic                        out_valid;

  assign prod_go   = !out_valid || result.ready;
  assign pkt_ready = !prod_valid || prod_go;

  assign voltage_held_next = prod_pkt.ok ? voltage_prod : voltage_held;
  assign current_held_next = prod_pkt.ok ? current_prod : current_held;
  assign power_held_next   = prod_pkt.ok ? power_prod   : power_held;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid   <= 1'b0;
      out_valid    <= 1'b0;
      voltage_held <= '0;
      current_held <= '0;
      power_held   <= '0;
    end else begin
      if (pkt_ready) begin
        prod_valid <= pkt_valid;
      end
      if (prod_go) begin
        out_valid <= prod_valid;
        if (prod_valid) begin
          voltage_held <= voltage_held_next;
          current_held <= current_held_next;
          power_held   <= power_held_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_valid && pkt_ready) begin
      prod_pkt     <= pkt;
      voltage_prod <= {{emd_pkg::SCALE_W{1'b0}}, pkt.voltage_raw}
                    * {{emd_pkg::RAW_W{1'b0}}, scales.voltage_scale};
      current_prod <= {{emd_pkg::SCALE_W{1'b0}}, pkt.current_raw}
                    * {{emd_pkg::RAW_W{1'b0}}, scales.current_scale};
      power_prod   <= {{emd_pkg::SCALE_W{1'b0}}, pkt.power_raw}
                    * {{emd_pkg::RAW_W{1'b0}}, scales.power_scale};
    end
    if (prod_valid && prod_go) begin
      result.checksum_ok    <= prod_pkt.ok;
      result.voltage_raw    <= prod_pkt.voltage_raw;
      result.current_raw    <= prod_pkt.current_raw;
      result.power_raw      <= prod_pkt.power_raw;
      result.voltage_scaled <= voltage_held_next;
      result.current_scaled <= current_held_next;
      result.power_scaled   <= power_held_next;
      result.received_sum   <= prod_pkt.received_sum;
      result.computed_sum   <= prod_pkt.computed_sum;
    end
  end

  assign result.valid = out_valid;

endmodule

// ===== rtl/energy_meter_packet_deframer_top.sv =====
// Top level: scale registers, framer and scaler of the energy meter packet deframer.
//
// Takes one serial byte per cycle and frames bytes by count into 24-byte
// packets. A packet's result passes through the packet register, the
// multiply register and the output register, in that order, before the
// result beat is valid on the output. Input stalls only
// while the output register holds a result that has not been taken and the
// stages behind it are full. Scale registers are written through cfg_we,
// cfg_index and cfg_data; indexes beyond the three registers are ignored.
module energy_meter_packet_deframer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [emd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [emd_pkg::SCALE_W-1:0]     cfg_data,
  emd_byte_if.sink                        rx,
  emd_result_if.source                    result
);

  emd_pkg::scales_t scales;
  emd_pkg::pkt_t    pkt;
  logic             pkt_valid;
  logic             pkt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scales.voltage_scale <= emd_pkg::VOLTAGE_SCALE_RST;
      scales.current_scale <= emd_pkg::CURRENT_SCALE_RST;
      scales.power_scale   <= emd_pkg::POWER_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        emd_pkg::REG_VOLTAGE_SCALE: scales.voltage_scale <= cfg_data;
        emd_pkg::REG_CURRENT_SCALE: scales.current_scale <= cfg_data;
        emd_pkg::REG_POWER_SCALE:   scales.power_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  emd_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt)
  );

  emd_scaler u_scaler (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt),
    .scales    (scales),
    .result    (result)
  );

endmodule
